>>> sv/kmeans_assign_and_update_defines.svh
// assertion macros for the kmeans assign and update block
// used by the checker; expects clk and rst_n in the calling scope
`ifndef KMEANS_ASSIGN_AND_UPDATE_DEFINES_SVH
`define KMEANS_ASSIGN_AND_UPDATE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define KMAAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmaau: same-cycle check failed");

// next-cycle implication, disabled in reset
`define KMAAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmaau: next-cycle check failed");

`endif

>>> sv/kmaau_pkg.sv
// shared types and constants for the kmeans assign and update block
// no dependencies
package kmaau_pkg;

    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int MAX_DIMS_DEF     = 16;
    localparam int COUNT_BITS_DEF   = 20;

    localparam int COORD_BITS   = 16;
    localparam int DIST_BITS    = 36;
    localparam int REG_BITS     = 5;
    localparam int IDX_BITS     = 4;
    localparam int CMD_BITS     = 2;
    localparam int CFG_IDX_BITS = 4;
    localparam int OUT_CL_BITS  = 5;

    typedef logic [CMD_BITS-1:0] cmd_t;
    localparam cmd_t CMD_LOAD   = 2'd0;
    localparam cmd_t CMD_POINT  = 2'd1;
    localparam cmd_t CMD_UPDATE = 2'd2;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_NUM_CLUSTERS = 4'd0;
    localparam cfg_idx_t CFG_NUM_DIMS     = 4'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_CRD,
        S_CCHK,
        S_SRD,
        S_SWR,
        U_CRD,
        U_CCHK,
        U_SRD,
        U_DIVS,
        U_DIVW,
        U_END,
        S_EMIT
    } kmaau_state_t;

endpackage

>>> sv/kmaau_ifs.sv
// item, result and configuration channels of the kmeans block
// depends on kmaau_pkg
interface kmaau_item_if;
    import kmaau_pkg::*;
    logic                         valid;
    logic                         ready;
    cmd_t                         command;
    logic [IDX_BITS-1:0]          cluster_index;
    logic [IDX_BITS-1:0]          coord_index;
    logic signed [COORD_BITS-1:0] coord_value;
    modport source (output valid, command, cluster_index, coord_index, coord_value,
                    input ready);
    modport sink (input valid, command, cluster_index, coord_index, coord_value,
                  output ready);
endinterface

interface kmaau_result_if;
    import kmaau_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [OUT_CL_BITS-1:0] assigned_cluster;
    logic [DIST_BITS-1:0]   squared_distance;
    logic                   update_done;
    modport source (output valid, assigned_cluster, squared_distance, update_done,
                    input ready);
    modport sink (input valid, assigned_cluster, squared_distance, update_done,
                  output ready);
endinterface

interface kmaau_cfg_if;
    import kmaau_pkg::*;
    logic                valid;
    logic                ready;
    cfg_idx_t            index;
    logic [REG_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/kmaau_div.sv
// restoring divider, one quotient bit per cycle, truncates toward zero
// signed dividend, unsigned divisor; depends on nothing
module kmaau_div #(
    parameter int DIVIDEND_BITS = 36,
    parameter int DIVISOR_BITS  = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]         divisor,
    output logic                            done,
    output logic signed [DIVIDEND_BITS-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic                     neg_reg, neg_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    trial_diff;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        trial_diff = trial - {1'b0, divisor};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_BITS);
            rem_next  = '0;
            neg_next  = dividend[DIVIDEND_BITS-1];
            quo_next  = dividend[DIVIDEND_BITS-1] ? unsigned'(-dividend) : unsigned'(dividend);
        end
        else if (busy_reg)
        begin
            // trial subtract of the divisor from the shifted remainder
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial_diff[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

>>> sv/kmeans_assign_and_update.sv
// kmeans assign and update: one Lloyd iteration in fixed point
// depends on kmaau_pkg, kmaau_ifs and kmaau_div
//
// Centroid coordinates are loaded one per item (command load) and point
// coordinates (command point) are buffered one per item; the coordinate
// with index num_dims-1 starts a scan with one shared subtractor, one
// 17x17 squarer and one saturating adder, stepping through the read,
// multiply and accumulate states for each centroid coordinate. The first
// point that lands in a cluster after reset or an update writes every one
// of the MAX_DIMS sums of that cluster. The nearest centroid (lowest index
// on a tie) is reported as a 1-based number with its squared distance, and
// the point is added into that cluster's sums and count unless the count
// has saturated. An update item walks the clusters in use and, for each one
// that is not empty, divides each of its sums in use by the count in a
// bit-serial divider of 36 steps, then clears all sums and counts and
// reports done. Sums and counts sit in memories with one valid flop per
// cluster row, so reset and update clear them at once. The item channel is
// not ready while a scan or update runs; the result sits in an output
// register so the next item is taken while it waits.
module kmeans_assign_and_update #(
    parameter int MAX_CLUSTERS = kmaau_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_DIMS     = kmaau_pkg::MAX_DIMS_DEF,
    parameter int COUNT_BITS   = kmaau_pkg::COUNT_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    kmaau_item_if.sink   item,
    kmaau_result_if.source result,
    kmaau_cfg_if.sink    cfg
);
    import kmaau_pkg::*;

    localparam int CW       = $clog2(MAX_CLUSTERS);
    localparam int DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DEPTH    = MAX_CLUSTERS * MAX_DIMS;
    localparam int AW       = $clog2(DEPTH);
    localparam int SUM_BITS = COORD_BITS + COUNT_BITS;
    localparam int SQ_BITS  = 2 * COORD_BITS + 2;

    // state and control
    kmaau_state_t state_reg, state_next;
    logic [REG_BITS-1:0] num_clusters_reg, num_dims_reg;
    logic [CW-1:0] c_reg, c_next;
    logic [DW-1:0] j_reg, j_next;
    logic [CW-1:0] best_reg, best_next;
    logic [MAX_CLUSTERS-1:0] row_valid_reg, row_valid_next;
    logic row_was_valid_reg, row_was_valid_next;
    logic emit_done_reg, emit_done_next;
    logic out_valid_reg, out_valid_next;

    // datapath
    logic [DIST_BITS-1:0] acc_reg, acc_next;
    logic [DIST_BITS-1:0] best_dist_reg, best_dist_next;
    logic [SQ_BITS-1:0] sq_reg, sq_next;
    logic [COUNT_BITS-1:0] cnt_val_reg, cnt_val_next;
    logic [OUT_CL_BITS-1:0] out_cl_reg;
    logic [DIST_BITS-1:0] out_dist_reg;
    logic out_done_reg;
    logic out_load;

    // memories
    logic signed [COORD_BITS-1:0] cent_mem [DEPTH];
    logic signed [COORD_BITS-1:0] pt_mem [MAX_DIMS];
    logic signed [SUM_BITS-1:0] sum_mem [DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem [MAX_CLUSTERS];
    logic signed [COORD_BITS-1:0] cent_rd_reg, pt_rd_reg;
    logic signed [SUM_BITS-1:0] sum_rd_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;

    logic cent_we, pt_we, sum_we, cnt_we;
    logic [AW-1:0] cent_waddr, row_addr;
    logic signed [COORD_BITS-1:0] cent_wdata;
    logic [DW-1:0] pt_waddr;
    logic signed [SUM_BITS-1:0] sum_wdata;
    logic [COUNT_BITS-1:0] cnt_wdata;

    logic [CW-1:0] nk_m1;
    logic [DW-1:0] nd_m1;
    logic accept, load_ok, pt_ok, pt_last;
    logic c_last, j_last;
    logic j_in_use, sum_end;
    logic signed [COORD_BITS:0] diff;
    logic signed [SQ_BITS-1:0] sq_full;
    logic [DIST_BITS:0] acc_sum;
    logic [DIST_BITS-1:0] acc_sat;
    logic [COUNT_BITS-1:0] cur_count;
    logic signed [SUM_BITS-1:0] sum_base;
    logic div_start, div_done;
    logic signed [SUM_BITS-1:0] div_quo;

    // registers out of range act as the nearest legal value
    always_comb
    begin
        if (num_clusters_reg == '0)
            nk_m1 = '0;
        else if (32'(num_clusters_reg) > MAX_CLUSTERS)
            nk_m1 = CW'(MAX_CLUSTERS - 1);
        else
            nk_m1 = CW'(num_clusters_reg - 1'b1);
        if (num_dims_reg == '0)
            nd_m1 = '0;
        else if (32'(num_dims_reg) > MAX_DIMS)
            nd_m1 = DW'(MAX_DIMS - 1);
        else
            nd_m1 = DW'(num_dims_reg - 1'b1);
    end

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign load_ok    = (32'(item.cluster_index) < MAX_CLUSTERS)
                        && (32'(item.coord_index) < MAX_DIMS);
    assign pt_ok      = (32'(item.coord_index) < MAX_DIMS);
    assign pt_last    = (32'(item.coord_index) == 32'(nd_m1));
    assign c_last     = (c_reg == nk_m1);
    assign j_last     = (j_reg == nd_m1);
    assign row_addr   = AW'(32'(c_reg) * MAX_DIMS + 32'(j_reg));
    // a fresh row gets all its sums written, unused coordinates as zero
    assign j_in_use   = (j_reg <= nd_m1);
    assign sum_end    = row_was_valid_reg ? j_last : (32'(j_reg) == MAX_DIMS - 1);

    // shared arithmetic: difference, square, saturating accumulate
    assign diff    = {cent_rd_reg[COORD_BITS-1], cent_rd_reg}
                     - {pt_rd_reg[COORD_BITS-1], pt_rd_reg};
    assign sq_full = diff * diff;
    assign acc_sum = {1'b0, acc_reg} + (DIST_BITS + 1)'(sq_reg);
    assign acc_sat = acc_sum[DIST_BITS] ? '1 : acc_sum[DIST_BITS-1:0];
    // an invalid row reads as zero count and zero sums
    assign cur_count = row_valid_reg[c_reg] ? cnt_rd_reg : '0;
    assign sum_base  = row_was_valid_reg ? sum_rd_reg : '0;
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);

    kmaau_div #(
        .DIVIDEND_BITS(SUM_BITS),
        .DIVISOR_BITS (COUNT_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(sum_rd_reg),
        .divisor (cnt_val_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_POINT && pt_ok && pt_last)
                        state_next = S_RD;
                    else if (item.command == CMD_UPDATE)
                        state_next = U_CRD;
                end
            end
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = (j_last && c_last) ? S_CRD : S_RD;
            S_CRD:  state_next = S_CCHK;
            S_CCHK: state_next = (cur_count != '1) ? S_SRD : S_EMIT;
            S_SRD:  state_next = S_SWR;
            S_SWR:  state_next = sum_end ? S_EMIT : S_SRD;
            U_CRD:  state_next = U_CCHK;
            U_CCHK:
            begin
                if (row_valid_reg[c_reg])
                    state_next = U_SRD;
                else
                    state_next = c_last ? U_END : U_CRD;
            end
            U_SRD:  state_next = U_DIVS;
            U_DIVS: state_next = U_DIVW;
            U_DIVW:
            begin
                if (div_done)
                begin
                    if (!j_last)
                        state_next = U_SRD;
                    else
                        state_next = c_last ? U_END : U_CRD;
                end
            end
            U_END:  state_next = S_EMIT;
            S_EMIT: state_next = out_load ? S_IDLE : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        c_next             = c_reg;
        j_next             = j_reg;
        best_next          = best_reg;
        best_dist_next     = best_dist_reg;
        acc_next           = acc_reg;
        sq_next            = sq_reg;
        cnt_val_next       = cnt_val_reg;
        row_valid_next     = row_valid_reg;
        row_was_valid_next = row_was_valid_reg;
        emit_done_next     = emit_done_reg;
        cent_we            = 1'b0;
        cent_waddr         = row_addr;
        cent_wdata         = div_quo[COORD_BITS-1:0];
        pt_we              = 1'b0;
        pt_waddr           = DW'(item.coord_index);
        sum_we             = 1'b0;
        sum_wdata          = sum_base
                             + (j_in_use ? {{(SUM_BITS-COORD_BITS){pt_rd_reg[COORD_BITS-1]}},
                                            pt_rd_reg} : '0);
        cnt_we             = 1'b0;
        cnt_wdata          = cur_count + 1'b1;
        div_start          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    c_next   = '0;
                    j_next   = '0;
                    acc_next = '0;
                    if (item.command == CMD_LOAD && load_ok)
                    begin
                        cent_we    = 1'b1;
                        cent_waddr = AW'(32'(item.cluster_index) * MAX_DIMS
                                         + 32'(item.coord_index));
                        cent_wdata = item.coord_value;
                    end
                    if (item.command == CMD_POINT && pt_ok)
                        pt_we = 1'b1;
                    emit_done_next = (item.command == CMD_UPDATE);
                end
            end
            S_MUL:  sq_next = unsigned'(sq_full);
            S_ACC:
            begin
                if (j_last)
                begin
                    // strict compare keeps the lowest index on a tie
                    acc_next = '0;
                    j_next   = '0;
                    if (c_reg == '0 || acc_sat < best_dist_reg)
                    begin
                        best_next      = c_reg;
                        best_dist_next = acc_sat;
                    end
                    if (c_last)
                        c_next = (c_reg == '0 || acc_sat < best_dist_reg) ? c_reg : best_reg;
                    else
                        c_next = c_reg + 1'b1;
                end
                else
                begin
                    acc_next = acc_sat;
                    j_next   = j_reg + 1'b1;
                end
            end
            S_CCHK:
            begin
                j_next = '0;
                if (cur_count != '1)
                begin
                    cnt_we                = 1'b1;
                    row_was_valid_next    = row_valid_reg[c_reg];
                    row_valid_next[c_reg] = 1'b1;
                end
            end
            S_SWR:
            begin
                sum_we = 1'b1;
                j_next = j_reg + 1'b1;
            end
            U_CCHK:
            begin
                j_next       = '0;
                cnt_val_next = cnt_rd_reg;
                if (!row_valid_reg[c_reg])
                    c_next = c_reg + 1'b1;
            end
            U_DIVS: div_start = 1'b1;
            U_DIVW:
            begin
                if (div_done)
                begin
                    cent_we = 1'b1;
                    if (j_last)
                        c_next = c_reg + 1'b1;
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            U_END:  row_valid_next = '0;
            S_RD, S_CRD, S_SRD, U_CRD, U_SRD, S_EMIT: ;
            default: ;
        endcase
    end

    // result handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_clusters_reg <= REG_BITS'(1);
            num_dims_reg     <= REG_BITS'(1);
            row_valid_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_NUM_CLUSTERS: num_clusters_reg <= cfg.data;
                    CFG_NUM_DIMS:     num_dims_reg     <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg             <= c_next;
        j_reg             <= j_next;
        best_reg          <= best_next;
        best_dist_reg     <= best_dist_next;
        acc_reg           <= acc_next;
        sq_reg            <= sq_next;
        cnt_val_reg       <= cnt_val_next;
        row_was_valid_reg <= row_was_valid_next;
        emit_done_reg     <= emit_done_next;
        if (out_load)
        begin
            out_cl_reg   <= emit_done_reg ? '0 : OUT_CL_BITS'(32'(best_reg) + 1);
            out_dist_reg <= emit_done_reg ? '0 : best_dist_reg;
            out_done_reg <= emit_done_reg;
        end
    end

    // memories with registered reads
    always_ff @(posedge clk)
    begin
        if (cent_we)
            cent_mem[cent_waddr] <= cent_wdata;
        cent_rd_reg <= cent_mem[row_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= item.coord_value;
        pt_rd_reg <= pt_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[row_addr] <= sum_wdata;
        sum_rd_reg <= sum_mem[row_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[c_reg] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[c_reg];
    end

    assign result.valid            = out_valid_reg;
    assign result.assigned_cluster = out_cl_reg;
    assign result.squared_distance = out_dist_reg;
    assign result.update_done      = out_done_reg;

endmodule

>>> sv/kmaau_chk.sv
// port-level checker for the kmeans block, bound to the top level
// depends on kmaau_pkg and the assertion macro header
`include "kmeans_assign_and_update_defines.svh"

module kmaau_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_valid,
    input logic                               item_ready,
    input kmaau_pkg::cmd_t                    item_command,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic [kmaau_pkg::OUT_CL_BITS-1:0]  result_cluster,
    input logic [kmaau_pkg::DIST_BITS-1:0]    result_distance,
    input logic                               result_done
);
    import kmaau_pkg::*;

    // a load item finishes in its own cycle
    `KMAAU_ASSERT_NXT(a_load_ready, item_valid && item_ready && item_command == CMD_LOAD, item_ready)
    // an update always takes the block busy
    `KMAAU_ASSERT_NXT(a_upd_busy, item_valid && item_ready && item_command == CMD_UPDATE, !item_ready)
    // done items carry no cluster and no distance
    `KMAAU_ASSERT_IMP(a_done_fields, result_valid && result_done, result_cluster == '0 && result_distance == '0)
    // stalled result holds
    `KMAAU_ASSERT_NXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(result_cluster))

endmodule

bind kmeans_assign_and_update kmaau_chk u_kmaau_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_command   (item.command),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_cluster (result.assigned_cluster),
    .result_distance(result.squared_distance),
    .result_done    (result.update_done)
);

>>> test/tb_kmeans_assign_and_update.sv
// self-checking testbench for kmeans_assign_and_update
// depends on kmaau_pkg, kmaau_ifs and the block's rtl
// directed and random items under several idle patterns, checked by a local predictor
module tb_kmeans_assign_and_update;
    timeunit 1ns;
    timeprecision 1ps;
    import kmaau_pkg::*;

    localparam int     NCL      = MAX_CLUSTERS_DEF;
    localparam int     NDM      = MAX_DIMS_DEF;
    localparam longint DIST_SAT = (longint'(1) << DIST_BITS) - 1;
    localparam longint CNT_SAT  = (longint'(1) << COUNT_BITS_DEF) - 1;
    localparam cmd_t   CMD_SPARE = 2'd3;  // unused code, block ignores it

    typedef struct packed {
        logic [OUT_CL_BITS-1:0] cluster;
        logic [DIST_BITS-1:0]   distance;
        logic                   done;
    } assign_result_t;

    logic clk;
    logic rst_n;

    kmaau_item_if   item ();
    kmaau_result_if result ();
    kmaau_cfg_if    cfg ();

    kmeans_assign_and_update u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // predictor state, a private copy of what the block holds
    longint          centroid_q[NCL][NDM];
    longint          point_q[NDM];
    bit              point_set[NDM];
    longint          sum_q[NCL][NDM];
    longint          count_q[NCL];
    logic [REG_BITS-1:0] reg_clusters;
    logic [REG_BITS-1:0] reg_dims;

    assign_result_t  pending_results[$];
    int              error_count;
    int              items_sent;
    int              src_idle_pct;
    int              snk_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall watchdog
    initial
    begin
        #30ms;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // append one expected result at the tail
    task automatic add_expected(input assign_result_t r);
        pending_results = {pending_results, r};
    endtask

    function automatic int clamp_reg(input logic [REG_BITS-1:0] v, input int hi);
        if (v == 0)
            return 1;
        return (int'(v) > hi) ? hi : int'(v);
    endfunction

    // nearest-centroid scan, accumulation and update, in step with accepted items
    task automatic predict_item(input cmd_t cmd, input logic [IDX_BITS-1:0] ci,
                                input logic [IDX_BITS-1:0] di,
                                input logic signed [COORD_BITS-1:0] val);
        int             nk;
        int             nd;
        int             best;
        longint         best_d;
        longint         d;
        longint         diff;
        assign_result_t r;
        nk = clamp_reg(reg_clusters, NCL);
        nd = clamp_reg(reg_dims, NDM);
        if (cmd == CMD_LOAD)
        begin
            centroid_q[ci][di] = longint'(val);
        end
        else if (cmd == CMD_POINT)
        begin
            point_q[di] = longint'(val);
            point_set[di] = 1'b1;
            if (int'(di) == nd - 1)
            begin
                best = 0;
                best_d = 0;
                for (int c = 0; c < nk; c++)
                begin
                    d = 0;
                    for (int j = 0; j < nd; j++)
                    begin
                        diff = centroid_q[c][j] - point_q[j];
                        d += diff * diff;
                        if (d > DIST_SAT)
                            d = DIST_SAT;
                    end
                    if (c == 0 || d < best_d)
                    begin
                        best = c;
                        best_d = d;
                    end
                end
                if (count_q[best] < CNT_SAT)
                begin
                    count_q[best]++;
                    for (int j = 0; j < nd; j++)
                        sum_q[best][j] += point_q[j];
                end
                r.cluster = OUT_CL_BITS'(best + 1);
                r.distance = DIST_BITS'(best_d);
                r.done = 1'b0;
                add_expected(r);
            end
        end
        else if (cmd == CMD_UPDATE)
        begin
            for (int c = 0; c < nk; c++)
                if (count_q[c] != 0)
                    for (int j = 0; j < nd; j++)
                        centroid_q[c][j] = sum_q[c][j] / count_q[c];
            for (int c = 0; c < NCL; c++)
            begin
                count_q[c] = 0;
                for (int j = 0; j < NDM; j++)
                    sum_q[c][j] = 0;
            end
            r.cluster = '0;
            r.distance = '0;
            r.done = 1'b1;
            add_expected(r);
        end
    endtask

    // one item on the input channel, with random idle cycles ahead of it
    task automatic send_item(input cmd_t cmd, input logic [IDX_BITS-1:0] ci,
                             input logic [IDX_BITS-1:0] di,
                             input logic signed [COORD_BITS-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item.valid = 1'b0;
            @(negedge clk);
        end
        item.valid = 1'b1;
        item.command = cmd;
        item.cluster_index = ci;
        item.coord_index = di;
        item.coord_value = val;
        do
            @(posedge clk);
        while (!item.ready);
        predict_item(cmd, ci, di, val);
        items_sent++;
    endtask

    // wait for every expected result, then let trailing loads settle
    task automatic drain;
        @(negedge clk);
        item.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(input cfg_idx_t idx, input logic [REG_BITS-1:0] data);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = data;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == CFG_NUM_CLUSTERS)
            reg_clusters = data;
        else if (idx == CFG_NUM_DIMS)
            reg_dims = data;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic set_shape(input logic [REG_BITS-1:0] k, input logic [REG_BITS-1:0] dm);
        drain();
        write_reg(CFG_NUM_CLUSTERS, k);
        write_reg(CFG_NUM_DIMS, dm);
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord;
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 16'sh8000;
        if (r == 1)
            return 16'sh7fff;
        return COORD_BITS'($urandom);
    endfunction

    task automatic send_point(input int nd);
        for (int j = 0; j < nd; j++)
            send_item(CMD_POINT, IDX_BITS'($urandom), IDX_BITS'(j), pick_coord());
    endtask

    // every centroid entry gets a value so no scan reads an unwritten entry
    task automatic test_table_load;
        for (int c = 0; c < NCL; c++)
            for (int j = 0; j < NDM; j++)
                send_item(CMD_LOAD, IDX_BITS'(c), IDX_BITS'(j), pick_coord());
    endtask

    // ties, coordinate extremes, stray coordinates, spare command, update
    task automatic test_directed;
        set_shape(5'd4, 5'd2);
        send_item(CMD_LOAD, 4'd0, 4'd0, 16'sd0);
        send_item(CMD_LOAD, 4'd0, 4'd1, 16'sd0);
        send_item(CMD_LOAD, 4'd1, 4'd0, 16'sd0);
        send_item(CMD_LOAD, 4'd1, 4'd1, 16'sd0);
        send_item(CMD_LOAD, 4'd2, 4'd0, 16'sh7fff);
        send_item(CMD_LOAD, 4'd2, 4'd1, 16'sh7fff);
        send_item(CMD_LOAD, 4'd3, 4'd0, 16'sh8000);
        send_item(CMD_LOAD, 4'd3, 4'd1, 16'sh8000);
        // update with every cluster empty keeps centroids
        send_item(CMD_UPDATE, 4'd0, 4'd0, 16'sd0);
        // exact tie between clusters one and two, lowest wins
        send_item(CMD_POINT, 4'd0, 4'd0, 16'sd0);
        send_item(CMD_POINT, 4'd0, 4'd1, 16'sd0);
        send_item(CMD_POINT, 4'd0, 4'd0, 16'sh7fff);
        send_item(CMD_POINT, 4'd0, 4'd1, 16'sh7fff);
        send_item(CMD_POINT, 4'd0, 4'd0, 16'sh8000);
        send_item(CMD_POINT, 4'd0, 4'd1, 16'sh8000);
        // widest distance: opposite corners
        send_item(CMD_POINT, 4'd0, 4'd0, 16'sh8000);
        send_item(CMD_POINT, 4'd0, 4'd1, 16'sh7fff);
        // last coordinate alone reuses the buffered first one
        send_item(CMD_POINT, 4'd0, 4'd1, 16'sh7fff);
        send_item(CMD_SPARE, 4'hf, 4'hf, 16'shffff);
        send_item(CMD_UPDATE, 4'hf, 4'hf, 16'sh7fff);
        send_item(CMD_POINT, 4'd0, 4'd0, -16'sd3);
        send_item(CMD_POINT, 4'd0, 4'd1, 16'sd5);
        send_item(CMD_UPDATE, 4'd0, 4'd0, 16'sd0);
    endtask

    // zero acts as one, values past the maximum act as the maximum
    task automatic test_register_extremes;
        set_shape(5'd0, 5'd0);
        send_point(1);
        send_item(CMD_UPDATE, 4'd0, 4'd0, 16'sd0);
        set_shape(5'd31, 5'd31);
        send_point(NDM);
        send_point(NDM);
        send_item(CMD_UPDATE, 4'd0, 4'd0, 16'sd0);
        set_shape(5'd16, 5'd16);
        send_point(NDM);
    endtask

    // mostly whole points with random content, some loads, updates and noise
    task automatic test_random(input int target, input logic [REG_BITS-1:0] k,
                               input logic [REG_BITS-1:0] dm);
        int  nd;
        int  r;
        int  di;
        int  stop_at;
        bit  ok;
        set_shape(k, dm);
        nd = clamp_reg(dm, NDM);
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 70)
                send_point(nd);
            else if (r < 82)
                send_item(CMD_LOAD, IDX_BITS'($urandom), IDX_BITS'($urandom), pick_coord());
            else if (r < 85)
                send_item(CMD_UPDATE, IDX_BITS'($urandom), IDX_BITS'($urandom),
                          COORD_BITS'($urandom));
            else if (r < 94)
            begin
                // stray coordinate; ends a point only if the buffer is filled
                di = $urandom_range(NDM - 1);
                ok = 1'b1;
                for (int j = 0; j < nd - 1; j++)
                    ok &= point_set[j];
                if (di == nd - 1 && !ok)
                    di = 0;
                send_item(CMD_POINT, IDX_BITS'($urandom), IDX_BITS'(di), pick_coord());
            end
            else
                send_item(CMD_SPARE, IDX_BITS'($urandom), IDX_BITS'($urandom),
                          COORD_BITS'($urandom));
        end
    endtask

    // receiver side: random stalls at the falling edge
    always @(negedge clk)
        result.ready <= ($urandom_range(99) >= snk_idle_pct);

    // result checker against the oldest expectation
    always @(posedge clk)
    begin
        assign_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, cluster", result.assigned_cluster, 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.assigned_cluster !== want.cluster)
                    report_mismatch("assigned_cluster", result.assigned_cluster, want.cluster);
                if (result.squared_distance !== want.distance)
                    report_mismatch("squared_distance", result.squared_distance,
                                    want.distance);
                if (result.update_done !== want.done)
                    report_mismatch("update_done", result.update_done, want.done);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.command = CMD_LOAD;
        item.cluster_index = '0;
        item.coord_index = '0;
        item.coord_value = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_NUM_CLUSTERS;
        cfg.data = '0;
        result.ready = 1'b0;
        error_count = 0;
        items_sent = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        reg_clusters = 5'd1;
        reg_dims = 5'd1;
        for (int c = 0; c < NCL; c++)
        begin
            count_q[c] = 0;
            for (int j = 0; j < NDM; j++)
            begin
                centroid_q[c][j] = 0;
                sum_q[c][j] = 0;
            end
        end
        for (int j = 0; j < NDM; j++)
        begin
            point_q[j] = 0;
            point_set[j] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_load();
        test_directed();
        test_register_extremes();

        // idle patterns: none, sender, receiver, both
        src_idle_pct = 0;  snk_idle_pct = 0;
        test_random(220, 5'd3, 5'd4);
        src_idle_pct = 46; snk_idle_pct = 0;
        test_random(220, 5'd16, 5'd16);
        src_idle_pct = 0;  snk_idle_pct = 46;
        test_random(220, 5'd1, 5'd1);
        src_idle_pct = 30; snk_idle_pct = 30;
        test_random(220, 5'd7, 5'd2);

        drain();
        repeat (50) @(negedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
